>>> rtl/bpfdc_pkg.sv
package bpfdc_pkg;

	localparam int DEPTH     = 64;
	localparam int ID_BITS   = 18;
	localparam int TIME_BITS = 30;

	// store address and held-count widths
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int FUNC_BITS  = 2;
	localparam int LIM_BITS   = 7;
	localparam int MATCH_BITS = 7;
	localparam int CMPW       = (CW > LIM_BITS) ? CW : LIM_BITS;

	localparam logic [LIM_BITS-1:0] LIMIT_RESET = LIM_BITS'(64);

	// operation codes
	localparam logic [FUNC_BITS-1:0] OP_ADD = 2'd0;
	localparam logic [FUNC_BITS-1:0] OP_FWD = 2'd1;
	localparam logic [FUNC_BITS-1:0] OP_CNT = 2'd2;

	// register indexes
	localparam logic REG_LIMIT = 1'b0;

	typedef struct packed {
		logic [FUNC_BITS-1:0] func;
		logic [ID_BITS-1:0]   source;
		logic [ID_BITS-1:0]   destination;
		logic [TIME_BITS-1:0] timestamp;
		logic [TIME_BITS-1:0] start_time;
		logic [TIME_BITS-1:0] end_time;
	} in_t;

	typedef struct packed {
		logic                  added;
		logic                  forward_valid;
		logic [ID_BITS-1:0]    out_source;
		logic [ID_BITS-1:0]    out_destination;
		logic [TIME_BITS-1:0]  out_timestamp;
		logic [MATCH_BITS-1:0] match_count;
	} out_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   src;
		logic [ID_BITS-1:0]   dst;
		logic [TIME_BITS-1:0] ts;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} status_t;

endpackage

>>> rtl/bpfdc_ctrl.sv
module bpfdc_ctrl import bpfdc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.step   = 1'b1;
				cmd.commit = status.scan_done & status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (status.scan_done && status.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/bpfdc_dp.sv
module bpfdc_dp import bpfdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  in_t                 in_data,
	input  logic [LIM_BITS-1:0] limit,
	output logic                out_valid,
	input  logic                out_ready,
	output out_t                out_data
);

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	entry_t mem [DEPTH];
	entry_t rd_s1;
	logic   rd_v_s1;

	in_t            req_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  match_q;
	logic           dup_q;
	logic           out_valid_q;
	out_t           out_q;

	logic [CW-1:0]   scan_len;
	logic            issue;
	logic [AW-1:0]   rd_addr;
	logic            hit_dup;
	logic            hit_cnt;
	logic [CMPW-1:0] lim_raw;
	logic [CMPW-1:0] lim_eff;
	logic            full;
	logic [AW-1:0]   head_inc;
	logic [AW-1:0]   wr_addr;
	logic            wr_en;
	out_t            res;

	always_comb begin
		case (req_q.func)
			OP_ADD:  scan_len = count_q;
			OP_CNT:  scan_len = count_q;
			OP_FWD:  scan_len = (count_q != '0) ? CW'(1) : '0;
			default: scan_len = '0;
		endcase
	end

	assign issue   = cmd.step && (idx_q < scan_len);
	assign rd_addr = wrap_add(head_q, idx_q[AW-1:0]);

	assign hit_dup = (rd_s1.src == req_q.source) && (rd_s1.dst == req_q.destination) &&
	                 (rd_s1.ts == req_q.timestamp);
	assign hit_cnt = (rd_s1.dst == req_q.destination) && (rd_s1.ts >= req_q.start_time) &&
	                 (rd_s1.ts <= req_q.end_time);

	// limit clamped to 1..DEPTH
	always_comb begin
		lim_raw = CMPW'(limit);
		if (lim_raw == '0) lim_eff = CMPW'(1);
		else if (lim_raw > CMPW'(DEPTH)) lim_eff = CMPW'(DEPTH);
		else lim_eff = lim_raw;
	end

	assign full     = CMPW'(count_q) >= lim_eff;
	assign head_inc = wrap_add(head_q, AW'(1));
	assign wr_addr  = wrap_add(head_q, count_q[AW-1:0]);
	assign wr_en    = cmd.commit && (req_q.func == OP_ADD) && !dup_q;

	always_comb begin
		res = '0;
		case (req_q.func)
			OP_ADD: begin
				res.added = !dup_q;
			end
			OP_FWD: begin
				if (count_q != '0) begin
					res.forward_valid   = 1'b1;
					res.out_source      = rd_s1.src;
					res.out_destination = rd_s1.dst;
					res.out_timestamp   = rd_s1.ts;
				end
			end
			OP_CNT: begin
				res.match_count = MATCH_BITS'(match_q);
			end
			default: begin
				res = '0;
			end
		endcase
	end

	assign status.scan_done = (idx_q >= scan_len) && !rd_v_s1;
	assign status.out_free  = !out_valid_q || out_ready;

	// packet store
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= '{src: req_q.source, dst: req_q.destination,
		                             ts: req_q.timestamp};
		if (issue) rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) req_q <= in_data;
		if (cmd.commit) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			match_q     <= '0;
			dup_q       <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (cmd.start) begin
				idx_q   <= '0;
				match_q <= '0;
				dup_q   <= 1'b0;
			end else begin
				if (issue) idx_q <= idx_q + CW'(1);
				if (rd_v_s1) begin
					dup_q <= dup_q | hit_dup;
					if (hit_cnt) match_q <= match_q + CW'(1);
				end
			end

			if (cmd.commit) begin
				case (req_q.func)
					OP_ADD: begin
						if (!dup_q) begin
							if (full) head_q <= head_inc;
							else count_q <= count_q + CW'(1);
						end
					end
					OP_FWD: begin
						if (count_q != '0) begin
							head_q  <= head_inc;
							count_q <= count_q - CW'(1);
						end
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end

			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/bounded_packet_fifo_dedup_count_core.sv
// Bounded packet buffer with duplicate filter and per-destination count.
// Input channel (in_valid/in_ready/in_data): one request per transfer;
//   func selects add, forward oldest, or count by destination and time range.
// Output channel (out_valid/out_ready/out_data): exactly one result transfer
//   per request, in request order.
// Config: APB-style port, register 0 (byte address 0) is memory_limit,
//   reset 64, clamped to 1..DEPTH in use. Write only while idle.
// Flow: a request is taken only when the block is idle. Add and count
//   requests walk the held entries through the single read port of the
//   packet store, one entry a cycle; forward reads only the oldest entry,
//   and unused codes read none. A new request is taken the cycle after
//   the result is loaded.
// Stall: the result sits in an output register; the next request is taken and
//   scanned while it waits, and its own result holds until the slot frees.
// Reset: arst_n clears head, count, and handshake state and restores the
//   limit; store contents are left as they are and never read unless written.
module bounded_packet_fifo_dedup_count_core import bpfdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [LIM_BITS-1:0] limit_q;
	cmd_t                cmd;
	status_t             status;

	// register write on the access phase; pready tied high
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
			limit_q <= pwdata[LIM_BITS-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_LIMIT) ? {{(32-LIM_BITS){1'b0}}, limit_q} : '0;

	bpfdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bpfdc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.limit     (limit_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
